/* sv/rpc_pkg.sv */
package rpc_pkg;

	localparam int DataW      = 16;
	localparam int OutW       = 17;
	localparam int FracBits   = 14;
	localparam int VecW       = 34;
	localparam int AngW       = 34;
	localparam int ProdW      = 48;
	localparam int MagProdW   = 63;
	localparam int IterDefault = 16;
	localparam int IterMax    = 32;

	// 1/K scaled by 2^30
	localparam logic [29:0] InvGain = 30'd652032874;

	localparam logic signed [AngW-1:0] PiUnits     = 34'sd2147483648;
	localparam logic signed [DataW-1:0] FoldThresh = 16'sd16384;

	localparam logic signed [63:0] MagMax = 64'sd46341;
	localparam logic signed [63:0] AngMax = 64'sd32767;
	localparam logic signed [63:0] AngMin = -64'sd32768;

	localparam logic KindToPolar = 1'b0;
	localparam logic KindToRect  = 1'b1;

	typedef logic signed [VecW-1:0] vec_t;
	typedef logic signed [AngW-1:0] ang_t;

	typedef struct packed {
		logic valid;
		logic kind;
		logic zero;
	} rpc_ctl_t;

	// arctan(2^-i) in units of pi/2^31
	function automatic ang_t atan_units(input int unsigned idx);
		ang_t r;
		case (idx)
			0:  r = 34'sd536870912;
			1:  r = 34'sd316933406;
			2:  r = 34'sd167458907;
			3:  r = 34'sd85004756;
			4:  r = 34'sd42667331;
			5:  r = 34'sd21354465;
			6:  r = 34'sd10679838;
			7:  r = 34'sd5340245;
			8:  r = 34'sd2670163;
			9:  r = 34'sd1335087;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41722;
			15: r = 34'sd20861;
			16: r = 34'sd10430;
			17: r = 34'sd5215;
			18: r = 34'sd2608;
			19: r = 34'sd1304;
			20: r = 34'sd652;
			21: r = 34'sd326;
			22: r = 34'sd163;
			23: r = 34'sd81;
			24: r = 34'sd41;
			25: r = 34'sd20;
			26: r = 34'sd10;
			27: r = 34'sd5;
			28: r = 34'sd3;
			29: r = 34'sd1;
			30: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [OutW-1:0] sat_coord(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v;
		if (v > MagMax) begin
			r = MagMax;
		end else if (v < -MagMax) begin
			r = -MagMax;
		end
		return r[OutW-1:0];
	endfunction

	function automatic logic signed [DataW-1:0] sat_word(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v;
		if (v > AngMax) begin
			r = AngMax;
		end else if (v < AngMin) begin
			r = AngMin;
		end
		return r[DataW-1:0];
	endfunction

endpackage

/* sv/rect_polar_converter.sv */
// Channel   Direction  Handshake             Payload
// req       in         req_valid / req_stall kind, first_in, second_in
// rsp       out        rsp_valid / rsp_stall first_out, second_out
//
// Stages: two entry stages, one stage per micro-rotation (ITERATIONS capped at 32),
// two exit stages. One transfer per cycle is taken while the pipeline is not held.
// The whole pipeline advances together; it holds only while a result sits in
// the output register and rsp_stall is high, and req_stall follows that.
// Reset clears all valid bits; payload registers are not reset.
module rect_polar_converter import rpc_pkg::*; #(
	parameter int ITERATIONS = IterDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic                    kind,
	input  logic signed [DataW-1:0] first_in,
	input  logic signed [DataW-1:0] second_in,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic signed [OutW-1:0]  first_out,
	output logic signed [DataW-1:0] second_out
);

	localparam int NumIter = (ITERATIONS > IterMax) ? IterMax : ITERATIONS;

	logic     adv;
	rpc_ctl_t rot_ctl [0:NumIter];
	vec_t     rot_x   [0:NumIter];
	vec_t     rot_y   [0:NumIter];
	ang_t     rot_z   [0:NumIter];
	rpc_ctl_t out_ctl;

	assign adv       = !rsp_valid || !rsp_stall;
	assign req_stall = !adv;
	assign rsp_valid = out_ctl.valid;

	rpc_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (req_valid),
		.kind      (kind),
		.first_in  (first_in),
		.second_in (second_in),
		.ctl_o     (rot_ctl[0]),
		.x_o       (rot_x[0]),
		.y_o       (rot_y[0]),
		.z_o       (rot_z[0])
	);

	for (genvar i = 0; i < NumIter; i++) begin : g_rot
		rpc_rot #(.Idx(i)) u_rot (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.ctl_i  (rot_ctl[i]),
			.x_i    (rot_x[i]),
			.y_i    (rot_y[i]),
			.z_i    (rot_z[i]),
			.ctl_o  (rot_ctl[i+1]),
			.x_o    (rot_x[i+1]),
			.y_o    (rot_y[i+1]),
			.z_o    (rot_z[i+1])
		);
	end

	rpc_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.ctl_i      (rot_ctl[NumIter]),
		.x_i        (rot_x[NumIter]),
		.y_i        (rot_y[NumIter]),
		.z_i        (rot_z[NumIter]),
		.ctl_o      (out_ctl),
		.first_out  (first_out),
		.second_out (second_out)
	);

	// a held pipeline keeps its items where they are
	a_hold_stages: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(rot_ctl[0]) && $stable(rot_ctl[NumIter]))
		else $error("pipeline moved while held");

	// magnitude from a vectoring pass is never negative
	a_mag_sign: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (out_ctl.kind == KindToPolar) |-> !first_out[OutW-1])
		else $error("negative magnitude");

	// only a rectangular input can be flagged as the zero vector
	a_zero_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rot_ctl[0].valid && rot_ctl[0].zero |-> rot_ctl[0].kind == KindToPolar)
		else $error("zero flag on polar input");

	a_first_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (first_out <= 17'sd46341) && (first_out >= -17'sd46341))
		else $error("first_out beyond saturation limit");

endmodule

/* sv/rpc_pre.sv */
module rpc_pre import rpc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic                    kind,
	input  logic signed [DataW-1:0] first_in,
	input  logic signed [DataW-1:0] second_in,
	output rpc_ctl_t                ctl_o,
	output vec_t                    x_o,
	output vec_t                    y_o,
	output ang_t                    z_o
);

	// stage 1: fold angle into +-pi/2 and prescale magnitude by 1/K
	logic                    fold_hi, fold_lo;
	logic signed [16:0]      m_ext, m_fold;
	logic signed [30:0]      inv_s;
	logic signed [ProdW-1:0] prod_c;
	ang_t                    z_raw, z_fold;

	assign fold_hi = second_in > FoldThresh;
	assign fold_lo = second_in < -FoldThresh;
	assign m_ext   = {first_in[DataW-1], first_in};
	assign m_fold  = (fold_hi || fold_lo) ? -m_ext : m_ext;
	assign inv_s   = $signed({1'b0, InvGain});
	assign prod_c  = m_fold * inv_s;
	assign z_raw   = {{2{second_in[DataW-1]}}, second_in, 16'b0};

	always_comb begin
		z_fold = z_raw;
		if (fold_hi) begin
			z_fold = z_raw - PiUnits;
		end else if (fold_lo) begin
			z_fold = z_raw + PiUnits;
		end
	end

	rpc_ctl_t                ctl_s1;
	logic signed [DataW-1:0] a_s1, b_s1;
	logic signed [ProdW-1:0] prod_s1;
	ang_t                    z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.kind  <= kind;
			ctl_s1.zero  <= (kind == KindToPolar) && (first_in == '0) && (second_in == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= first_in;
			b_s1    <= second_in;
			prod_s1 <= prod_c;
			z_s1    <= z_fold;
		end
	end

	// stage 2: starting vector for the rotations
	vec_t                    xs, ys, x_c, y_c;
	ang_t                    z_c;
	logic signed [ProdW-1:0] prod_rnd;

	assign xs       = {{4{a_s1[DataW-1]}}, a_s1, {FracBits{1'b0}}};
	assign ys       = {{4{b_s1[DataW-1]}}, b_s1, {FracBits{1'b0}}};
	assign prod_rnd = (prod_s1 + (ProdW'(1) <<< 15)) >>> 16;

	always_comb begin
		if (ctl_s1.kind == KindToRect) begin
			x_c = prod_rnd[VecW-1:0];
			y_c = '0;
			z_c = z_s1;
		end else if (a_s1[DataW-1]) begin
			// left half plane: turn by pi first
			x_c = -xs;
			y_c = -ys;
			z_c = b_s1[DataW-1] ? -PiUnits : PiUnits;
		end else begin
			x_c = xs;
			y_c = ys;
			z_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_o <= x_c;
			y_o <= y_c;
			z_o <= z_c;
		end
	end

endmodule

/* sv/rpc_rot.sv */
module rpc_rot import rpc_pkg::*; #(
	parameter int unsigned Idx = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  rpc_ctl_t ctl_i,
	input  vec_t     x_i,
	input  vec_t     y_i,
	input  ang_t     z_i,
	output rpc_ctl_t ctl_o,
	output vec_t     x_o,
	output vec_t     y_o,
	output ang_t     z_o
);

	localparam ang_t Atan = atan_units(Idx);

	logic ccw;
	vec_t dx, dy;

	// rotation mode steers by the residual angle, vectoring mode by the sign of y
	assign ccw = (ctl_i.kind == KindToRect) ? !z_i[AngW-1] : y_i[VecW-1];
	assign dx  = y_i >>> Idx;
	assign dy  = x_i >>> Idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_o <= ccw ? x_i - dx : x_i + dx;
			y_o <= ccw ? y_i + dy : y_i - dy;
			z_o <= ccw ? z_i - Atan : z_i + Atan;
		end
	end

endmodule

/* sv/rpc_post.sv */
module rpc_post import rpc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  rpc_ctl_t                ctl_i,
	input  vec_t                    x_i,
	input  vec_t                    y_i,
	input  ang_t                    z_i,
	output rpc_ctl_t                ctl_o,
	output logic signed [OutW-1:0]  first_out,
	output logic signed [DataW-1:0] second_out
);

	// stage 1: gain multiply for magnitude, rounding of the other results
	logic signed [31:0]         x32;
	logic signed [30:0]         inv_s;
	logic signed [MagProdW-1:0] prod_c;
	vec_t                       rx, ry;
	ang_t                       ra;

	// magnitude after vectoring stays below 2^31
	assign x32    = x_i[31:0];
	assign inv_s  = $signed({1'b0, InvGain});
	assign prod_c = x32 * inv_s;
	assign rx     = (x_i + (VecW'(1) <<< (FracBits - 1))) >>> FracBits;
	assign ry     = (y_i + (VecW'(1) <<< (FracBits - 1))) >>> FracBits;
	assign ra     = (z_i + (AngW'(1) <<< 15)) >>> 16;

	rpc_ctl_t                   ctl_s1;
	logic signed [MagProdW-1:0] prod_s1;
	logic signed [OutW-1:0]     fx_s1;
	logic signed [DataW-1:0]    fy_s1, ang_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_c;
			fx_s1   <= sat_coord(64'(rx));
			fy_s1   <= sat_word(64'(ry));
			ang_s1  <= sat_word(64'(ra));
		end
	end

	// stage 2: output register
	logic signed [MagProdW-1:0] mag_c;
	logic signed [OutW-1:0]     first_c;
	logic signed [DataW-1:0]    second_c;

	assign mag_c = (prod_s1 + (MagProdW'(1) <<< 43)) >>> 44;

	always_comb begin
		if (ctl_s1.kind == KindToRect) begin
			first_c  = fx_s1;
			second_c = fy_s1;
		end else if (ctl_s1.zero) begin
			first_c  = '0;
			second_c = '0;
		end else begin
			first_c  = sat_coord(64'(mag_c));
			second_c = ang_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			first_out  <= first_c;
			second_out <= second_c;
		end
	end

endmodule

/* tb/tb.sv */
module tb;
	import rpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int Iters  = IterDefault;
	localparam int NumRot = (Iters > IterMax) ? IterMax : Iters;

	localparam longint InvGainL  = 64'sd652032874;
	localparam longint PiL       = 64'sd2147483648;
	localparam longint HalfPiL   = 64'sd1073741824;
	localparam longint CoordLim  = 64'sd46341;
	localparam longint WordMax   = 64'sd32767;
	localparam longint WordMin   = -64'sd32768;

	// arctan(2^-i) in units of pi/2^31
	localparam longint AtanTab [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1, 0
	};

	typedef struct {
		logic signed [OutW-1:0]  first;
		logic signed [DataW-1:0] second;
	} conv_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    req_valid = 1'b0;
	logic                    req_stall;
	logic                    kind      = KindToPolar;
	logic signed [DataW-1:0] first_in  = '0;
	logic signed [DataW-1:0] second_in = '0;
	logic                    rsp_valid;
	logic                    rsp_stall = 1'b0;
	logic signed [OutW-1:0]  first_out;
	logic signed [DataW-1:0] second_out;

	conv_t converted_q [$];
	int    errors      = 0;
	int    n_polar     = 0;
	int    n_rect      = 0;
	int    n_checked   = 0;
	bit    src_gaps    = 1'b0;
	bit    snk_stalls  = 1'b0;
	int    stall_left  = 0;

	rect_polar_converter #(.ITERATIONS(Iters)) dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#1ms;
		$display("simulation failed");
		$finish;
	end

	// CORDIC in fixed point: coordinates scaled by 2^14, angle in pi/2^31 units
	function automatic conv_t convert_vector(input logic k, input logic signed [DataW-1:0] f,
			input logic signed [DataW-1:0] s);
		longint x, y, z, m, tx, ty, r0, r1;
		conv_t r;
		if (k == KindToPolar) begin
			if (f == 0 && s == 0) begin
				r0 = 0;
				r1 = 0;
			end else begin
				x = longint'(f) * 16384;
				y = longint'(s) * 16384;
				z = 0;
				// fold left half-plane into the right one
				if (x < 0) begin
					z = (y >= 0) ? PiL : -PiL;
					x = -x;
					y = -y;
				end
				for (int i = 0; i < NumRot; i++) begin
					tx = y >>> i;
					ty = x >>> i;
					if (y >= 0) begin
						x += tx;
						y -= ty;
						z += AtanTab[i];
					end else begin
						x -= tx;
						y += ty;
						z -= AtanTab[i];
					end
				end
				r0 = (x * InvGainL + 64'sh80000000000) >>> 44;
				r1 = (z + 32768) >>> 16;
			end
		end else begin
			z = longint'(s) * 65536;
			m = longint'(f);
			if (z > HalfPiL) begin
				z -= PiL;
				m = -m;
			end else if (z < -HalfPiL) begin
				z += PiL;
				m = -m;
			end
			x = (m * InvGainL + 32768) >>> 16;
			y = 0;
			for (int i = 0; i < NumRot; i++) begin
				tx = y >>> i;
				ty = x >>> i;
				if (z >= 0) begin
					x -= tx;
					y += ty;
					z -= AtanTab[i];
				end else begin
					x += tx;
					y -= ty;
					z += AtanTab[i];
				end
			end
			r0 = (x + 8192) >>> 14;
			r1 = (y + 8192) >>> 14;
		end
		if (r0 > CoordLim) r0 = CoordLim;
		if (r0 < -CoordLim) r0 = -CoordLim;
		if (r1 > WordMax) r1 = WordMax;
		if (r1 < WordMin) r1 = WordMin;
		r.first  = r0[OutW-1:0];
		r.second = r1[DataW-1:0];
		return r;
	endfunction

	function automatic logic signed [DataW-1:0] rand_word();
		logic signed [DataW-1:0] v;
		case ($urandom_range(0, 3))
			0: v = $signed(16'($urandom_range(0, 16)) - 16'd8);
			1: begin
				case ($urandom_range(0, 5))
					0: v = -16'sd32768;
					1: v = -16'sd32767;
					2: v = -16'sd1;
					3: v = 16'sd0;
					4: v = 16'sd1;
					default: v = 16'sd32767;
				endcase
			end
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	task automatic send_vec(input logic k, input logic signed [DataW-1:0] f,
			input logic signed [DataW-1:0] s);
		int gap;
		gap = src_gaps ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		kind      <= k;
		first_in  <= f;
		second_in <= s;
		do @(posedge clk); while (req_stall);
		converted_q.push_back(convert_vector(k, f, s));
		if (k == KindToPolar) n_polar++;
		else n_rect++;
	endtask

	task automatic send_random(input int count);
		for (int n = 0; n < count; n++) begin
			send_vec(logic'($urandom_range(0, 1)), rand_word(), rand_word());
		end
	endtask

	// sink: check each transfer, then hold off a random number of cycles if snk_stalls is set
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			if (converted_q.size() == 0) begin
				$error("unexpected result: first_out %0d second_out %0d", first_out, second_out);
				errors++;
			end else begin
				conv_t e;
				e = converted_q.pop_front();
				n_checked++;
				if (first_out !== e.first) begin
					$error("first_out: expected %0d, got %0d", e.first, first_out);
					errors++;
				end
				if (second_out !== e.second) begin
					$error("second_out: expected %0d, got %0d", e.second, second_out);
					errors++;
				end
			end
			stall_left = snk_stalls ? $urandom_range(0, 3) : 0;
		end else if (stall_left > 0) begin
			stall_left--;
		end
		rsp_stall <= (stall_left > 0);
	end

	task automatic test_polar_corners();
		src_gaps   = 1'b1;
		snk_stalls = 1'b1;
		send_vec(KindToPolar, 16'sd0, 16'sd0);           // zero vector
		send_vec(KindToPolar, 16'sd32767, 16'sd0);
		send_vec(KindToPolar, -16'sd32768, 16'sd0);      // angle of pi saturates
		send_vec(KindToPolar, -16'sd1, 16'sd0);
		send_vec(KindToPolar, 16'sd0, 16'sd32767);
		send_vec(KindToPolar, 16'sd0, -16'sd32768);
		send_vec(KindToPolar, -16'sd32768, -16'sd32768); // largest magnitude
		send_vec(KindToPolar, 16'sd32767, 16'sd32767);
		send_vec(KindToPolar, -16'sd32768, 16'sd32767);
		send_vec(KindToPolar, 16'sd32767, -16'sd32768);
		send_vec(KindToPolar, 16'sd1, 16'sd0);
		send_vec(KindToPolar, -16'sd1, -16'sd1);
	endtask

	task automatic test_rect_corners();
		send_vec(KindToRect, 16'sd32767, 16'sd0);
		send_vec(KindToRect, 16'sd32767, 16'sd16384);
		send_vec(KindToRect, 16'sd32767, 16'sd16385);
		send_vec(KindToRect, 16'sd32767, -16'sd16385);
		send_vec(KindToRect, 16'sd32767, -16'sd32768);
		send_vec(KindToRect, -16'sd32768, 16'sd0);       // wide result
		send_vec(KindToRect, -16'sd32768, 16'sd16384);
		send_vec(KindToRect, -16'sd32768, -16'sd32768);
		send_vec(KindToRect, -16'sd1, -16'sd16384);      // negative magnitude
		send_vec(KindToRect, 16'sd0, 16'sd12345);
		send_vec(KindToRect, 16'sd100, 16'sd32767);
		send_vec(KindToRect, -16'sd32767, 16'sd8192);
	endtask

	task automatic test_full_rate();
		src_gaps   = 1'b0;
		snk_stalls = 1'b0;
		send_random(200);
	endtask

	task automatic test_sink_backpressure();
		src_gaps   = 1'b0;
		snk_stalls = 1'b1;
		send_random(200);
	endtask

	task automatic test_source_gaps();
		src_gaps   = 1'b1;
		snk_stalls = 1'b0;
		send_random(150);
	endtask

	task automatic test_mixed_idling();
		src_gaps   = 1'b1;
		snk_stalls = 1'b1;
		send_random(350);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_polar_corners();
		test_rect_corners();
		test_full_rate();
		test_sink_backpressure();
		test_source_gaps();
		test_mixed_idling();
		req_valid <= 1'b0;
		while (converted_q.size() != 0) @(posedge clk);
		repeat (Iters + 8) @(posedge clk);
		$display("checked %0d results: %0d rect-to-polar and %0d polar-to-rect transfers",
			n_checked, n_polar, n_rect);
		$display("corner vectors, then random vectors at full rate and with gaps and stalls");
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
